// File: rtl/core/dapid_pkg.sv
// dapid_pkg: shared widths, constants and types for the dual-axis incremental PID.
// Used by dapid_lane, dapid_merge, dual_axis_incremental_pid and dapid_check.
package dapid_pkg;

  localparam int POS_BITS       = 8;
  localparam int GAIN_FRAC_BITS = 12;
  localparam int ACC_BITS       = 32;

  localparam int GAIN_W = 16;
  localparam int DUTY_W = 16;
  localparam int CTRL_W = 19;

  localparam int ERR_W  = POS_BITS + 1;
  localparam int D1_W   = POS_BITS + 2;
  localparam int D2_W   = POS_BITS + 3;
  localparam int PROD_W = GAIN_W + 1 + D2_W;
  localparam int INC_W  = PROD_W + 2;
  localparam int SUM_W  = ((ACC_BITS > INC_W) ? ACC_BITS : INC_W) + 1;
  localparam int U_W    = GAIN_FRAC_BITS + 7;

  localparam int NUM_AXES = 2;

  // configuration registers
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_P_X = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I_X = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D_X = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_GAIN_P_Y = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I_Y = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D_Y = REG_IDX_W'(5);
  localparam logic [REG_IDX_W-1:0] REG_MID_X    = REG_IDX_W'(6);
  localparam logic [REG_IDX_W-1:0] REG_MID_Y    = REG_IDX_W'(7);
  localparam logic [GAIN_W-1:0] REG_RESET [NUM_REGS] = '{
    16'd819, 16'd0, 16'd2867, 16'd819, 16'd0, 16'd2048, 16'd2818, 16'd4456
  };

  // accumulator bounds and output limits, Q.F
  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
  localparam int ONE_Q = 2 ** GAIN_FRAC_BITS;
  localparam logic signed [ACC_BITS-1:0] LIM_X_HI = ACC_BITS'(20 * ONE_Q);
  localparam logic signed [ACC_BITS-1:0] LIM_X_LO = ACC_BITS'(-40 * ONE_Q);
  localparam logic signed [ACC_BITS-1:0] LIM_Y_HI = ACC_BITS'(50 * ONE_Q);
  localparam logic signed [ACC_BITS-1:0] LIM_Y_LO = ACC_BITS'(-50 * ONE_Q);

  // duty offset = floor((u * 2^(17-F) + 1000) / 2000)
  //             = floor(floor(n / 16) / 125), the last by reciprocal plus one fix-up
  localparam int DUTY_HALF   = 1000;
  localparam int DUTY_PRE_SH = 17 - GAIN_FRAC_BITS;
  localparam int N_W         = U_W + DUTY_PRE_SH + 1;
  localparam int DUTY_SH     = 4;
  localparam int M_W         = N_W - DUTY_SH;
  localparam int DUTY_DIV    = 125;
  localparam int DUTY_BIAS   = (2 ** (M_W - 1)) / DUTY_DIV + 1;
  localparam int DUTY_BIAS_M = DUTY_BIAS * DUTY_DIV;
  localparam int MP_W        = M_W + 1;
  localparam int RCP_SH      = MP_W + 8;
  localparam int RCP_W       = RCP_SH - 6;
  localparam int RCP         = (2 ** RCP_SH) / DUTY_DIV;
  localparam int Q_W         = MP_W - 5;
  localparam int DS_W        = ((DUTY_W + 1 > Q_W + 1) ? DUTY_W + 1 : Q_W + 1) + 1;

  typedef enum logic [1:0] {
    TERM_P,
    TERM_I,
    TERM_D
  } term_e;

  typedef struct packed {
    logic  start;
    logic  mac;
    term_e sel;
    logic  commit;
  } lane_ctl_t;

  typedef struct packed {
    logic signed [U_W-1:0] ctrl;
    logic                  clip;
  } lane_res_t;

  typedef struct packed {
    logic prep;
    logic mul;
    logic fix;
  } mrg_ctl_t;

endpackage

// File: rtl/core/dapid_lane.sv
// dapid_lane: one axis of the incremental PID, error history, shared MAC and accumulator.
// Depends on dapid_pkg.
module dapid_lane (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  dapid_pkg::lane_ctl_t                   ctl_i,
  input  logic [dapid_pkg::POS_BITS-1:0]         meas_i,
  input  logic [dapid_pkg::POS_BITS-1:0]         target_i,
  input  logic [dapid_pkg::GAIN_W-1:0]           kp_i,
  input  logic [dapid_pkg::GAIN_W-1:0]           ki_i,
  input  logic [dapid_pkg::GAIN_W-1:0]           kd_i,
  input  logic signed [dapid_pkg::ACC_BITS-1:0]  lim_lo_i,
  input  logic signed [dapid_pkg::ACC_BITS-1:0]  lim_hi_i,
  output dapid_pkg::lane_res_t                   res_o
);

  logic signed [dapid_pkg::ERR_W-1:0]    err_last_q, err_prev_q, err_cur, ei_q;
  logic signed [dapid_pkg::D1_W-1:0]     d1, d1_q;
  logic signed [dapid_pkg::D2_W-1:0]     d2, d2_q, term;
  logic        [dapid_pkg::GAIN_W-1:0]   gain;
  logic signed [dapid_pkg::PROD_W-1:0]   prod;
  logic signed [dapid_pkg::INC_W-1:0]    inc_q;
  logic signed [dapid_pkg::SUM_W-1:0]    sum;
  logic signed [dapid_pkg::ACC_BITS-1:0] acc_q, acc_sat, u_full;
  logic                                  clip;

  always_comb begin
    err_cur = $signed({1'b0, target_i}) - $signed({1'b0, meas_i});
    d1 = dapid_pkg::D1_W'(err_cur) - dapid_pkg::D1_W'(err_last_q);
    d2 = dapid_pkg::D2_W'(err_cur) - (dapid_pkg::D2_W'(err_last_q) <<< 1)
       + dapid_pkg::D2_W'(err_prev_q);
  end

  always_comb begin
    case (ctl_i.sel)
      dapid_pkg::TERM_P: begin
        term = dapid_pkg::D2_W'(d1_q);
        gain = kp_i;
      end
      dapid_pkg::TERM_I: begin
        term = dapid_pkg::D2_W'(ei_q);
        gain = ki_i;
      end
      dapid_pkg::TERM_D: begin
        term = d2_q;
        gain = kd_i;
      end
      default: begin
        term = '0;
        gain = '0;
      end
    endcase
    prod = $signed({1'b0, gain}) * term;
  end

  always_comb begin
    sum = dapid_pkg::SUM_W'(acc_q) + dapid_pkg::SUM_W'(inc_q);
    if (sum > dapid_pkg::SUM_W'(dapid_pkg::ACC_MAX)) begin
      acc_sat = dapid_pkg::ACC_MAX;
    end else if (sum < dapid_pkg::SUM_W'(dapid_pkg::ACC_MIN)) begin
      acc_sat = dapid_pkg::ACC_MIN;
    end else begin
      acc_sat = dapid_pkg::ACC_BITS'(sum);
    end
  end

  always_comb begin
    u_full = acc_q;
    clip   = 1'b0;
    if (acc_q > lim_hi_i) begin
      u_full = lim_hi_i;
      clip   = 1'b1;
    end else if (acc_q < lim_lo_i) begin
      u_full = lim_lo_i;
      clip   = 1'b1;
    end
  end

  assign res_o.ctrl = dapid_pkg::U_W'(u_full);
  assign res_o.clip = clip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_last_q <= '0;
      err_prev_q <= '0;
      acc_q      <= '0;
    end else begin
      if (ctl_i.start) begin
        err_prev_q <= err_last_q;
        err_last_q <= err_cur;
      end
      if (ctl_i.commit) begin
        acc_q <= acc_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      ei_q  <= err_cur;
      d1_q  <= d1;
      d2_q  <= d2;
      inc_q <= '0;
    end else if (ctl_i.mac) begin
      inc_q <= inc_q + dapid_pkg::INC_W'(prod);
    end
  end

endmodule

// File: rtl/core/dapid_merge.sv
// dapid_merge: turns both lanes' control values into servo duties (divide by 2000, round).
// Depends on dapid_pkg.
module dapid_merge (
  input  logic                          clk_i,
  input  dapid_pkg::mrg_ctl_t           ctl_i,
  input  dapid_pkg::lane_res_t          res_x_i,
  input  dapid_pkg::lane_res_t          res_y_i,
  input  logic [dapid_pkg::DUTY_W-1:0]  mid_x_i,
  input  logic [dapid_pkg::DUTY_W-1:0]  mid_y_i,
  output logic [dapid_pkg::DUTY_W-1:0]  duty_x_o,
  output logic [dapid_pkg::DUTY_W-1:0]  duty_y_o
);

  logic signed [dapid_pkg::U_W-1:0]                    u     [dapid_pkg::NUM_AXES];
  logic        [dapid_pkg::DUTY_W-1:0]                 mid   [dapid_pkg::NUM_AXES];
  logic        [dapid_pkg::DUTY_W-1:0]                 duty  [dapid_pkg::NUM_AXES];
  logic signed [dapid_pkg::N_W-1:0]                    num   [dapid_pkg::NUM_AXES];
  logic        [dapid_pkg::MP_W-1:0]                   mp    [dapid_pkg::NUM_AXES];
  logic        [dapid_pkg::MP_W-1:0]                   mp_q  [dapid_pkg::NUM_AXES];
  logic        [dapid_pkg::MP_W+dapid_pkg::RCP_W-1:0]  rprod [dapid_pkg::NUM_AXES];
  logic        [dapid_pkg::MP_W-1:0]                   rem   [dapid_pkg::NUM_AXES];
  logic        [dapid_pkg::Q_W-1:0]                    q0_q  [dapid_pkg::NUM_AXES];
  logic        [dapid_pkg::Q_W-1:0]                    q_fix [dapid_pkg::NUM_AXES];
  logic        [dapid_pkg::Q_W-1:0]                    q_q   [dapid_pkg::NUM_AXES];
  logic signed [dapid_pkg::DS_W-1:0]                   off   [dapid_pkg::NUM_AXES];
  logic signed [dapid_pkg::DS_W-1:0]                   dsum  [dapid_pkg::NUM_AXES];

  assign u[0]     = res_x_i.ctrl;
  assign u[1]     = res_y_i.ctrl;
  assign mid[0]   = mid_x_i;
  assign mid[1]   = mid_y_i;
  assign duty_x_o = duty[0];
  assign duty_y_o = duty[1];

  always_comb begin
    for (int i = 0; i < dapid_pkg::NUM_AXES; i++) begin
      num[i] = (dapid_pkg::N_W'(u[i]) <<< dapid_pkg::DUTY_PRE_SH)
             + dapid_pkg::N_W'(dapid_pkg::DUTY_HALF);
      // biased so the quotient search stays unsigned
      mp[i] = dapid_pkg::MP_W'(num[i] >>> dapid_pkg::DUTY_SH)
            + dapid_pkg::MP_W'(dapid_pkg::DUTY_BIAS_M);
      rprod[i] = mp_q[i] * dapid_pkg::RCP_W'(dapid_pkg::RCP);
      rem[i] = mp_q[i] - dapid_pkg::MP_W'(q0_q[i] * dapid_pkg::DUTY_DIV);
      q_fix[i] = (rem[i] >= dapid_pkg::MP_W'(dapid_pkg::DUTY_DIV)) ? q0_q[i] + 1'b1 : q0_q[i];
      off[i] = dapid_pkg::DS_W'($signed({1'b0, q_q[i]}))
             - dapid_pkg::DS_W'(dapid_pkg::DUTY_BIAS);
      if (i == 0) begin
        dsum[i] = dapid_pkg::DS_W'($signed({1'b0, mid[i]})) + off[i];
      end else begin
        dsum[i] = dapid_pkg::DS_W'($signed({1'b0, mid[i]})) - off[i];
      end
      if (dsum[i] < 0) begin
        duty[i] = '0;
      end else if (dsum[i] > dapid_pkg::DS_W'({dapid_pkg::DUTY_W{1'b1}})) begin
        duty[i] = '1;
      end else begin
        duty[i] = dapid_pkg::DUTY_W'(dsum[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < dapid_pkg::NUM_AXES; i++) begin
      if (ctl_i.prep) begin
        mp_q[i] <= mp[i];
      end
      if (ctl_i.mul) begin
        q0_q[i] <= dapid_pkg::Q_W'(rprod[i] >> dapid_pkg::RCP_SH);
      end
      if (ctl_i.fix) begin
        q_q[i] <= q_fix[i];
      end
    end
  end

endmodule

// File: rtl/core/dual_axis_incremental_pid.sv
// Two-axis incremental PID for a ball-on-plate servo pair.
// Input channel (in_valid_i / in_stall_o) takes one word per frame: measured and target
// ball position for x and y. Output channel (out_valid_o / out_stall_i) returns one word
// per input: clamped control values, servo duties and clip flags.
// Each axis runs in its own lane; a lane walks its three gain products through one
// shared multiplier, then adds the increment into a saturating accumulator. A merge
// stage then divides both control values by 2000 in three steps to form the duties.
// A result shows on out_valid_o after the accept, the 4 lane steps (3 MAC +
// accumulate), the 3 steps of the duty division and the output load; in_stall_o is high
// from the accept until the output load, so no new word is taken before that load.
// The result sits in an output register, so the next word is taken while it waits.
// If out_stall_i holds the output register full when a new result is done, the block
// waits and keeps in_stall_o high until the register frees.
// Reset clears the error history and accumulators, empties the output register and
// loads the gain and mid-duty registers with their defaults.
// Configuration (cfg_valid_i / cfg_ready_o) is always ready; the user must write it only while
// no word is in flight, as the block itself does not enforce this.
// Depends on dapid_pkg, dapid_lane, dapid_merge.
module dual_axis_incremental_pid (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [dapid_pkg::POS_BITS-1:0]        meas_x_i,
  input  logic [dapid_pkg::POS_BITS-1:0]        meas_y_i,
  input  logic [dapid_pkg::POS_BITS-1:0]        target_x_i,
  input  logic [dapid_pkg::POS_BITS-1:0]        target_y_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [dapid_pkg::CTRL_W-1:0]   ctrl_x_o,
  output logic signed [dapid_pkg::CTRL_W-1:0]   ctrl_y_o,
  output logic [dapid_pkg::DUTY_W-1:0]          duty_x_o,
  output logic [dapid_pkg::DUTY_W-1:0]          duty_y_o,
  output logic                                  clip_x_o,
  output logic                                  clip_y_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [dapid_pkg::REG_IDX_W-1:0]       cfg_index_i,
  input  logic [dapid_pkg::GAIN_W-1:0]          cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LANE,
    ST_PREP,
    ST_MUL,
    ST_FIX,
    ST_OUT
  } state_e;

  localparam logic [1:0] LAST_STEP = 2'd3;

  state_e                              state_q;
  logic [1:0]                          cnt_q;
  logic                                in_acc, out_free, out_load;
  logic [dapid_pkg::GAIN_W-1:0]        cfg_q [dapid_pkg::NUM_REGS];
  dapid_pkg::lane_ctl_t                lane_ctl;
  dapid_pkg::mrg_ctl_t                 mrg_ctl;
  dapid_pkg::lane_res_t                res_x, res_y;
  logic [dapid_pkg::DUTY_W-1:0]        duty_x, duty_y;
  logic                                out_valid_q;
  logic signed [dapid_pkg::CTRL_W-1:0] ctrl_x_q, ctrl_y_q;
  logic [dapid_pkg::DUTY_W-1:0]        duty_x_q, duty_y_q;
  logic                                clip_x_q, clip_y_q;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == ST_OUT) && out_free;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    lane_ctl.start  = in_acc;
    lane_ctl.mac    = (state_q == ST_LANE) && (cnt_q != LAST_STEP);
    lane_ctl.sel    = dapid_pkg::term_e'(cnt_q);
    lane_ctl.commit = (state_q == ST_LANE) && (cnt_q == LAST_STEP);
    mrg_ctl.prep    = (state_q == ST_PREP);
    mrg_ctl.mul     = (state_q == ST_MUL);
    mrg_ctl.fix     = (state_q == ST_FIX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dapid_pkg::NUM_REGS; i++) begin
        cfg_q[i] <= dapid_pkg::REG_RESET[i];
      end
    end else if (cfg_valid_i) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  dapid_lane u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (lane_ctl),
    .meas_i   (meas_x_i),
    .target_i (target_x_i),
    .kp_i     (cfg_q[dapid_pkg::REG_GAIN_P_X]),
    .ki_i     (cfg_q[dapid_pkg::REG_GAIN_I_X]),
    .kd_i     (cfg_q[dapid_pkg::REG_GAIN_D_X]),
    .lim_lo_i (dapid_pkg::LIM_X_LO),
    .lim_hi_i (dapid_pkg::LIM_X_HI),
    .res_o    (res_x)
  );

  dapid_lane u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (lane_ctl),
    .meas_i   (meas_y_i),
    .target_i (target_y_i),
    .kp_i     (cfg_q[dapid_pkg::REG_GAIN_P_Y]),
    .ki_i     (cfg_q[dapid_pkg::REG_GAIN_I_Y]),
    .kd_i     (cfg_q[dapid_pkg::REG_GAIN_D_Y]),
    .lim_lo_i (dapid_pkg::LIM_Y_LO),
    .lim_hi_i (dapid_pkg::LIM_Y_HI),
    .res_o    (res_y)
  );

  dapid_merge u_merge (
    .clk_i    (clk_i),
    .ctl_i    (mrg_ctl),
    .res_x_i  (res_x),
    .res_y_i  (res_y),
    .mid_x_i  (cfg_q[dapid_pkg::REG_MID_X]),
    .mid_y_i  (cfg_q[dapid_pkg::REG_MID_Y]),
    .duty_x_o (duty_x),
    .duty_y_o (duty_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      ctrl_x_q    <= '0;
      ctrl_y_q    <= '0;
      duty_x_q    <= '0;
      duty_y_q    <= '0;
      clip_x_q    <= 1'b0;
      clip_y_q    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_LANE;
            cnt_q   <= '0;
          end
        end
        ST_LANE: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == LAST_STEP) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: state_q <= ST_MUL;
        ST_MUL:  state_q <= ST_FIX;
        ST_FIX:  state_q <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            state_q     <= ST_IDLE;
            ctrl_x_q    <= dapid_pkg::CTRL_W'(res_x.ctrl);
            ctrl_y_q    <= dapid_pkg::CTRL_W'(res_y.ctrl);
            duty_x_q    <= duty_x;
            duty_y_q    <= duty_y;
            clip_x_q    <= res_x.clip;
            clip_y_q    <= res_y.clip;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign ctrl_x_o    = ctrl_x_q;
  assign ctrl_y_o    = ctrl_y_q;
  assign duty_x_o    = duty_x_q;
  assign duty_y_o    = duty_y_q;
  assign clip_x_o    = clip_x_q;
  assign clip_y_o    = clip_y_q;

endmodule

// File: rtl/core/dapid_check.sv
// dapid_check: port-level checks for dual_axis_incremental_pid, attached by bind.
// Depends on dapid_pkg.
module dapid_check (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic signed [dapid_pkg::CTRL_W-1:0]   ctrl_x_o,
  input logic signed [dapid_pkg::CTRL_W-1:0]   ctrl_y_o,
  input logic                                  clip_x_o,
  input logic                                  clip_y_o
);

  localparam logic signed [dapid_pkg::CTRL_W-1:0] X_HI = dapid_pkg::CTRL_W'(dapid_pkg::LIM_X_HI);
  localparam logic signed [dapid_pkg::CTRL_W-1:0] X_LO = dapid_pkg::CTRL_W'(dapid_pkg::LIM_X_LO);
  localparam logic signed [dapid_pkg::CTRL_W-1:0] Y_HI = dapid_pkg::CTRL_W'(dapid_pkg::LIM_Y_HI);
  localparam logic signed [dapid_pkg::CTRL_W-1:0] Y_LO = dapid_pkg::CTRL_W'(dapid_pkg::LIM_Y_LO);

  // a word in flight blocks the next one
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while previous word still in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_clip_x_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clip_x_o) |-> (ctrl_x_o == X_HI || ctrl_x_o == X_LO))
    else $error("x clip flagged but ctrl_x not at a limit");

  a_y_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !clip_y_o) |-> (ctrl_y_o >= Y_LO && ctrl_y_o <= Y_HI))
    else $error("unclipped ctrl_y outside limits");

endmodule

bind dual_axis_incremental_pid dapid_check u_dapid_check (.*);
